[design/dtfp_pkg.sv]
package dtfp_pkg;

  localparam int FRAC_DIGITS_DEFAULT = 4;
  localparam int FRAC_DIGITS_MAX     = 9;
  localparam int CHAR_W              = 8;
  localparam int VALUE_W             = 63;
  localparam int DEC_W               = 4;
  localparam int POW10_W             = 30;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
  localparam logic [DEC_W-1:0]   DEC_CAP   = {DEC_W{1'b1}};

  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  // Finished text handed from the parser to the scaling pipeline.
  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic [DEC_W-1:0]   scale_exp;
    logic               fault;
  } parse_res_t;

  function automatic logic [POW10_W-1:0] pow10(input logic [DEC_W-1:0] k);
    logic [POW10_W-1:0] p;
    case (k)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

[design/dtfp_parse.sv]
module dtfp_parse #(
  parameter int FRAC_DIGITS = dtfp_pkg::FRAC_DIGITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dtfp_pkg::CHAR_W-1:0]     s_tdata,
  input  logic                            s_tuser,
  input  logic                            s_tlast,
  output logic                            res_valid,
  input  logic                            res_ready,
  output dtfp_pkg::parse_res_t            res
);

  localparam logic [dtfp_pkg::DEC_W-1:0] FracLimit = dtfp_pkg::DEC_W'(FRAC_DIGITS);

  // input register
  logic                        in_valid;
  logic [dtfp_pkg::CHAR_W-1:0] in_char;
  logic                        in_has;
  logic                        in_last;

  // text state
  logic [dtfp_pkg::VALUE_W-1:0] acc;
  logic                         dot_seen;
  logic [dtfp_pkg::DEC_W-1:0]   dec_seen;
  logic                         fault;
  logic                         any_char;

  logic [dtfp_pkg::VALUE_W-1:0] acc_next;
  logic                         dot_seen_next;
  logic [dtfp_pkg::DEC_W-1:0]   dec_seen_next;
  logic                         fault_next;
  logic                         any_char_next;

  logic                         is_dot;
  logic                         is_digit;
  logic [dtfp_pkg::DEC_W-1:0]   digit;
  logic [dtfp_pkg::VALUE_W+3:0] acc_wide;
  logic                         fire;
  logic                         end_fault;

  assign fire     = in_valid && (!in_last || !res_valid || res_ready);
  assign s_tready = !in_valid || fire;

  assign is_dot   = in_char == dtfp_pkg::CHAR_DOT;
  assign is_digit = (in_char >= dtfp_pkg::CHAR_ZERO) && (in_char <= dtfp_pkg::CHAR_NINE);
  assign digit    = dtfp_pkg::DEC_W'(in_char - dtfp_pkg::CHAR_ZERO);

  // acc * 10 + digit, four guard bits show an overflow past the 63-bit range
  assign acc_wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
                  + (dtfp_pkg::VALUE_W + 4)'(digit);

  always_comb begin
    acc_next      = acc;
    dot_seen_next = dot_seen;
    dec_seen_next = dec_seen;
    fault_next    = fault;
    any_char_next = any_char;
    if (in_has) begin
      any_char_next = 1'b1;
      if (is_dot) begin
        if (dot_seen) begin
          fault_next = 1'b1;
        end
        dot_seen_next = 1'b1;
      end else if (!is_digit) begin
        fault_next = 1'b1;
      end else begin
        if (acc_wide[dtfp_pkg::VALUE_W+3:dtfp_pkg::VALUE_W] != 4'b0) begin
          acc_next = dtfp_pkg::VALUE_MAX;
        end else begin
          acc_next = acc_wide[dtfp_pkg::VALUE_W-1:0];
        end
        if (dot_seen) begin
          if (dec_seen != dtfp_pkg::DEC_CAP) begin
            dec_seen_next = dec_seen + 1'b1;
          end
          if (dec_seen_next > FracLimit) begin
            fault_next = 1'b1;
          end
        end
      end
    end
  end

  assign end_fault = fault_next || !any_char_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_has  <= s_tuser;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && in_last)) begin
      acc      <= '0;
      dot_seen <= 1'b0;
      dec_seen <= '0;
      fault    <= 1'b0;
      any_char <= 1'b0;
    end else if (fire) begin
      acc      <= acc_next;
      dot_seen <= dot_seen_next;
      dec_seen <= dec_seen_next;
      fault    <= fault_next;
      any_char <= any_char_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && in_last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (fire && in_last) begin
      res.acc       <= acc_next;
      res.fault     <= end_fault;
      // The fault path covers every case where the count exceeds the limit.
      res.scale_exp <= end_fault ? '0 : FracLimit - dec_seen_next;
    end
  end

endmodule

[design/dtfp_scale.sv]
module dtfp_scale #(
  parameter int FRAC_DIGITS = dtfp_pkg::FRAC_DIGITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_valid,
  output logic                 res_ready,
  input  dtfp_pkg::parse_res_t res,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,
  output logic                 m_tuser
);

  localparam longint ScaleMax = 64'(10 ** FRAC_DIGITS);
  localparam int     ScaleW   = $clog2(ScaleMax + 1);
  localparam int     LoW      = 32;
  localparam int     HiW      = dtfp_pkg::VALUE_W - LoW;
  localparam int     SumW     = dtfp_pkg::VALUE_W + ScaleW + 1;

  logic [ScaleW-1:0]     scale;
  logic [LoW+ScaleW-1:0] p_lo;
  logic [HiW+ScaleW-1:0] p_hi;
  logic                  prod_bad;
  logic                  prod_valid;
  logic [SumW-1:0]       total;
  logic                  out_free;
  logic                  prod_free;
  logic [dtfp_pkg::VALUE_W-1:0] value_next;

  assign out_free  = !m_tvalid || m_tready;
  assign prod_free = !prod_valid || out_free;
  assign res_ready = prod_free;

  assign scale = ScaleW'(dtfp_pkg::pow10(res.scale_exp));

  // Two narrow partial products instead of one 63-bit multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_free) begin
      prod_valid <= res_valid;
    end
    if (prod_free && res_valid) begin
      p_lo     <= (LoW + ScaleW)'(res.acc[LoW-1:0]) * (LoW + ScaleW)'(scale);
      p_hi     <= (HiW + ScaleW)'(res.acc[dtfp_pkg::VALUE_W-1:LoW]) * (HiW + ScaleW)'(scale);
      prod_bad <= res.fault;
    end
  end

  assign total = (SumW'(p_hi) << LoW) + SumW'(p_lo);

  always_comb begin
    if (prod_bad) begin
      value_next = '0;
    end else if (total[SumW-1:dtfp_pkg::VALUE_W] != '0) begin
      value_next = dtfp_pkg::VALUE_MAX;
    end else begin
      value_next = total[dtfp_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= prod_valid;
    end
    if (out_free && prod_valid) begin
      m_tdata <= {1'b0, value_next};
      m_tuser <= prod_bad;
    end
  end

endmodule

[design/decimal_text_to_fixed_point_top.sv]
// Channel  | Data                                  | Side info
// ---------+---------------------------------------+------------------------------
// s_*      | tdata[7:0] character                  | tuser[0] has_char, tlast last
// m_*      | tdata[62:0] value, tdata[63] zero     | tuser[0] bad_text
//
// One character request is taken per cycle unless a tlast request waits for a held result.
// The request that carries tlast passes the input register, digit accumulate, a split 32-bit
// partial-product multiply by the final power of ten, then the saturating sum.
// The output register holds a stalled result while characters keep flowing in.
// Reset is synchronous; it empties every stage and clears the text state.
module decimal_text_to_fixed_point_top #(
  parameter int FRAC_DIGITS = dtfp_pkg::FRAC_DIGITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [dtfp_pkg::CHAR_W-1:0] s_tdata,   // [7:0] character
  input  logic                        s_tuser,   // [0] has_char
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata,   // [62:0] value, [63] zero
  output logic                        m_tuser    // [0] bad_text
);

  dtfp_pkg::parse_res_t res;
  logic                 res_valid;
  logic                 res_ready;

  dtfp_parse #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  dtfp_scale #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

[design/dtfp_checker.sv]
module dtfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // A bad text always reports a zero value.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 64'd0)
    else $error("bad text with nonzero value");

  // Reset empties the output stage.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind decimal_text_to_fixed_point_top dtfp_checker u_dtfp_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

[verif/dtfp_fixed_point_checker.sv]
`timescale 1ns / 100ps

// Watches both channels. It folds each accepted character request into its
// own copy of the text state and queues the fixed-point value that the end
// mark should produce. Each result is then checked against the oldest entry.
module dtfp_fixed_point_checker #(
  parameter int FRAC_DIGITS = dtfp_pkg::FRAC_DIGITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [dtfp_pkg::CHAR_W-1:0] s_tdata,   // [7:0] character
  input  logic                        s_tuser,   // [0] has_char
  input  logic                        s_tlast,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [63:0]                 m_tdata,   // [62:0] value, [63] zero
  input  logic                        m_tuser,   // [0] bad_text
  output int                          fail_count,
  output int                          pending,
  output int                          texts_done,
  output int                          bad_texts,
  output int                          saturated_texts
);
  import dtfp_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               bad_text;
  } fixed_result_t;

  fixed_result_t expected_fixed[$];

  // Text state as the parser should hold it.
  logic [VALUE_W-1:0] acc       = '0;
  logic               dot_seen  = 1'b0;
  logic [DEC_W-1:0]   decimals  = '0;
  logic               fault     = 1'b0;
  logic               any_char  = 1'b0;
  logic               saturated = 1'b0;

  int errors  = 0;
  int n_texts = 0;
  int n_bad   = 0;
  int n_sat   = 0;

  task automatic clear_text();
    acc       = '0;
    dot_seen  = 1'b0;
    decimals  = '0;
    fault     = 1'b0;
    any_char  = 1'b0;
    saturated = 1'b0;
  endtask

  // acc = acc * 10 + d, pinned at the top of the range once it would overflow.
  task automatic shift_in_digit(input logic [3:0] d);
    logic [VALUE_W-1:0] headroom;
    if (!saturated) begin
      headroom = (VALUE_MAX - VALUE_W'(d)) / 10;
      if (acc > headroom) begin
        acc       = VALUE_MAX;
        saturated = 1'b1;
      end else begin
        acc = acc * 10 + VALUE_W'(d);
      end
    end
  endtask

  task automatic fold_char(input logic [CHAR_W-1:0] c);
    any_char = 1'b1;
    if (c == CHAR_DOT) begin
      if (dot_seen) fault = 1'b1;
      dot_seen = 1'b1;
    end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
      fault = 1'b1;
    end else begin
      shift_in_digit(4'(c - CHAR_ZERO));
      if (dot_seen) begin
        if (decimals < DEC_CAP) decimals = decimals + 1'b1;
        if (decimals > FRAC_DIGITS) fault = 1'b1;
      end
    end
  endtask

  task automatic close_text(output fixed_result_t res);
    int k;
    if (!any_char) fault = 1'b1;
    if (fault) begin
      res.value    = '0;
      res.bad_text = 1'b1;
    end else begin
      // Pad the missing decimals so every value carries the same scale.
      for (k = int'(decimals); k < FRAC_DIGITS; k++) shift_in_digit(4'd0);
      res.value    = acc;
      res.bad_text = 1'b0;
    end
    clear_text();
  endtask

  task automatic log_mismatch(input string what, input logic [63:0] got,
                              input logic got_bad, input fixed_result_t want);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] %s: expected value %0d bad_text %0b, got value %0d pad %0b bad_text %0b",
               $realtime, what, want.value, want.bad_text, got[VALUE_W-1:0], got[63], got_bad);
    end
  endtask

  always @(posedge clk) begin
    fixed_result_t want;
    if (rst) begin
      clear_text();
      expected_fixed.delete();
    end else begin
      // A result never belongs to the request accepted in the same cycle,
      // so the result side is handled first.
      if (m_tvalid && m_tready) begin
        if (expected_fixed.size() == 0) begin
          log_mismatch("result with nothing expected", m_tdata, m_tuser, '0);
        end else begin
          want = expected_fixed.pop_front();
          if (m_tdata[VALUE_W-1:0] !== want.value || m_tdata[63] !== 1'b0 ||
              m_tuser !== want.bad_text) begin
            log_mismatch("wrong result", m_tdata, m_tuser, want);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser) fold_char(s_tdata);
        if (s_tlast) begin
          close_text(want);
          expected_fixed.push_back(want);
          n_texts++;
          if (want.bad_text) n_bad++;
          else if (want.value == VALUE_MAX) n_sat++;
        end
      end
    end
    pending         <= expected_fixed.size();
    fail_count      <= errors;
    texts_done      <= n_texts;
    bad_texts       <= n_bad;
    saturated_texts <= n_sat;
  end

endmodule

[verif/tb_decimal_text_to_fixed_point_top.sv]
`timescale 1ns / 100ps

module tb_decimal_text_to_fixed_point_top;
  import dtfp_pkg::*;

  localparam int FRAC       = FRAC_DIGITS_DEFAULT;
  localparam int TEXT_ITEMS = 1900;
  localparam int IDLE_LIMIT = 4000;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_COMB} rx_mode_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [CHAR_W-1:0] s_tdata  = '0;
  logic              s_tuser  = 1'b0;
  logic              s_tlast  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [63:0]       m_tdata;
  logic              m_tuser;

  int fail_count;
  int pending;
  int texts_done;
  int bad_texts;
  int saturated_texts;

  int       items_sent  = 0;
  int       burst_left  = 0;
  int       idle_cycles = 0;
  rx_mode_t rx_mode     = RX_OPEN;
  int       rx_left     = 0;
  logic [2:0] rx_tick   = '0;
  logic       paused    = 1'b0;

  logic [CHAR_W-1:0] text_chars[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  decimal_text_to_fixed_point_top #(
    .FRAC_DIGITS(FRAC)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  dtfp_fixed_point_checker #(
    .FRAC_DIGITS(FRAC)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .fail_count     (fail_count),
    .pending        (pending),
    .texts_done     (texts_done),
    .bad_texts      (bad_texts),
    .saturated_texts(saturated_texts)
  );

  // The result side cycles through stall patterns of random duration.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 300);
      end else begin
        rx_left <= rx_left - 1;
      end
      rx_tick <= rx_tick + 1'b1;
      case (rx_mode)
        RX_OPEN:  m_tready <= 1'b1;
        RX_LIGHT: m_tready <= ($urandom_range(0, 9) < 7);
        RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
        default:  m_tready <= (rx_tick[1:0] == 2'd0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles.", IDLE_LIMIT);
        $display("** decimal_text_to_fixed_point_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [CHAR_W-1:0] c, input logic has, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom);
        s_tuser  <= 1'($urandom);
        s_tlast  <= 1'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= has;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    if (has || eot) items_sent++;
  endtask

  // With plain cleared, empty requests are sprinkled into the text and the
  // end mark sometimes travels on its own.
  task automatic emit_text(input logic plain);
    int   i;
    logic split_end;
    split_end = !plain && ($urandom_range(0, 4) == 0);
    if (text_chars.size() == 0) split_end = 1'b1;
    for (i = 0; i < text_chars.size(); i++) begin
      if (!plain && $urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(text_chars[i], 1'b1, !split_end && i == text_chars.size() - 1);
    end
    if (split_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic send_string(input string s);
    int i;
    text_chars.delete();
    for (i = 0; i < s.len(); i++) text_chars.push_back(s[i]);
    emit_text(1'b1);
  endtask

  task automatic add_digits(input int n);
    repeat (n) text_chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic build_text();
    string near_max;
    int    kind;
    int    pos;
    int    i;
    near_max = "922337203685477";
    text_chars.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // Straddles the saturation point once the final scale is applied.
      for (i = 0; i < near_max.len(); i++) text_chars.push_back(near_max[i]);
      text_chars.push_back(CHAR_DOT);
      text_chars.push_back(CHAR_ZERO + 8'd5);
      text_chars.push_back(CHAR_ZERO + 8'd8);
      add_digits(FRAC - 2);
    end else if (kind < 90) begin
      add_digits(($urandom_range(0, 9) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 6));
      if ($urandom_range(0, 3) != 0) begin
        text_chars.push_back(CHAR_DOT);
        add_digits(($urandom_range(0, 7) == 0) ? $urandom_range(FRAC + 1, FRAC + 3)
                                               : $urandom_range(0, FRAC));
      end
      if (kind >= 72) begin
        pos = $urandom_range(0, text_chars.size());
        case ($urandom_range(0, 4))
          0:       text_chars.insert(pos, CHAR_DOT);
          1:       text_chars.insert(pos, CHAR_PLUS);
          2:       text_chars.insert(pos, CHAR_MINUS);
          3:       text_chars.insert(pos, CHAR_SPACE);
          default: text_chars.insert(pos, 8'($urandom));
        endcase
      end
    end else begin
      repeat ($urandom_range(0, 3)) text_chars.push_back(8'($urandom));
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_string("");
    send_string("0");
    send_string("9");
    send_string(".");
    send_string("5.");
    send_string(".9999");
    send_string("1..");
    send_string("-");
    send_string("+");
    send_string(" ");
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    // An empty request in the middle of a text must not break it up.
    send_item(CHAR_ZERO + 8'd7, 1'b1, 1'b0);
    send_item(CHAR_DOT, 1'b0, 1'b0);
    send_item(CHAR_ZERO + 8'd8, 1'b1, 1'b1);
    drain_results();

    while (items_sent < TEXT_ITEMS) begin
      build_text();
      emit_text(1'b0);
      if (!paused && items_sent >= TEXT_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (12) @(posedge clk);
    $display("Sent %0d character and end requests forming %0d numbers.", items_sent, texts_done);
    $display("Of those, %0d were rejected as bad text and %0d hit the saturation limit.",
             bad_texts, saturated_texts);
    if (fail_count == 0 && pending == 0) begin
      $display("** decimal_text_to_fixed_point_top: PASSED **");
    end else begin
      $display("** decimal_text_to_fixed_point_top: FAILED **");
    end
    $finish;
  end

endmodule
